[src/rpvg_pkg.sv]
package rpvg_pkg;

  // Geometry and number formats
  localparam int MAX_SIDES       = 64;
  localparam int COEFF_FRAC_BITS = 16;
  localparam int COEFF_W         = COEFF_FRAC_BITS + 2;    // signed Q2.F
  localparam int RADIUS_W        = 15;                     // unsigned Q2.13
  localparam int SIDES_IN_W      = 7;
  localparam int COORD_W         = 16;                     // signed Q3.13
  localparam int COORD_FRAC      = 13;
  localparam int IDX_W           = 6;
  localparam int RUN_W           = 24;                     // signed Q4.20
  localparam int RUN_FRAC        = 20;
  localparam int SIDES_W         = $clog2(MAX_SIDES + 1);
  localparam int MIN_SIDES       = 3;

  localparam int PROD_W      = RUN_W + COEFF_W;
  localparam int SUM_W       = PROD_W + 1;
  localparam int TAN_SHIFT   = COEFF_FRAC_BITS + COORD_FRAC - RUN_FRAC;
  localparam int OUT_SHIFT   = RUN_FRAC - COORD_FRAC;
  localparam int RUN_MAX     = 2 ** (RUN_W - 1) - 1;
  localparam int RUN_MIN     = -(2 ** (RUN_W - 1));

  localparam int QUEUE_DEPTH = 2;

  typedef logic signed [RUN_W-1:0]   run_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COEFF_W-1:0] coeff_w_t;
  typedef logic [SIDES_W-1:0]        sides_t;

  typedef struct packed {
    coeff_w_t cos_v;
    coeff_w_t sin_v;
    coeff_w_t tan_v;
  } coeff_t;

  localparam int COEFF_BITS = $bits(coeff_t);
  typedef logic [MAX_SIDES:0][COEFF_BITS-1:0] coeff_rom_t;

  // One polygon handed from the front to the back
  typedef struct packed {
    run_t     run_x;
    run_t     run_y;
    coord_t   center_x;
    coord_t   center_y;
    coeff_w_t step_cos;
    coeff_w_t step_sin;
    sides_t   sides;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MULT,
    F_PUSH
  } front_state_e;

  typedef enum logic {
    B_IDLE,
    B_RUN
  } back_state_e;

  function automatic run_t sat_run(input logic signed [SUM_W-1:0] v);
    if (v > SUM_W'(RUN_MAX)) return run_t'(RUN_MAX);
    if (v < SUM_W'(RUN_MIN)) return run_t'(RUN_MIN);
    return RUN_W'(v);
  endfunction

  // ---- Coefficient table, evaluated at elaboration only ----
  localparam logic [63:0] PI2_Q60 = 64'h6487_ED51_10B4_611A;
  localparam logic [63:0] HALF30  = 64'h0000_0000_2000_0000;
  localparam logic [63:0] ONE30   = 64'h0000_0000_4000_0000;

  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    int          i;
    q = '0;
    r = '0;
    for (i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= den) begin
        r    = r - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic signed [63:0] series_q30(input logic [63:0] a, input logic cosine);
    logic [63:0]        a2;
    logic [63:0]        term;
    logic [63:0]        k;
    logic signed [63:0] sum;
    logic               neg;
    int                 i;
    a2   = (a * a + HALF30) >> 30;
    term = cosine ? ONE30 : a;
    k    = cosine ? 64'd0 : 64'd1;
    sum  = signed'(term);
    neg  = 1'b0;
    for (i = 0; i < 30; i++) begin
      if (term != 64'd0) begin
        term = udiv64((term * a2 + HALF30) >> 30, (k + 64'd1) * (k + 64'd2));
        k    = k + 64'd2;
        neg  = !neg;
        if (neg) sum = sum - signed'(term);
        else     sum = sum + signed'(term);
      end
    end
    return sum;
  endfunction

  function automatic logic signed [63:0] round_away(input logic signed [63:0] v, input int sh);
    logic [63:0] half;
    half = 64'd1 << (sh - 1);
    if (v >= 0) return signed'((unsigned'(v) + half) >> sh);
    return -signed'((unsigned'(-v) + half) >> sh);
  endfunction

  function automatic coeff_t coeff_entry(input int n);
    logic [63:0]        ang;
    logic signed [63:0] c30;
    logic signed [63:0] s30;
    logic [63:0]        den;
    logic [63:0]        t30;
    coeff_t             e;
    ang = (udiv64(PI2_Q60, 64'(n)) + HALF30) >> 30;
    c30 = series_q30(ang, 1'b1);
    s30 = series_q30(ang, 1'b0);
    if (s30 < 0) s30 = '0;
    den = ONE30 + unsigned'(c30);
    if (den == 64'd0) den = 64'd1;
    t30 = udiv64((unsigned'(s30) << 30) + (den >> 1), den);
    e.cos_v = COEFF_W'(round_away(c30, 30 - COEFF_FRAC_BITS));
    e.sin_v = COEFF_W'(round_away(s30, 30 - COEFF_FRAC_BITS));
    e.tan_v = COEFF_W'(round_away(signed'(t30), 30 - COEFF_FRAC_BITS));
    return e;
  endfunction

  function automatic coeff_rom_t build_rom();
    coeff_rom_t rom;
    int         n;
    for (n = 0; n <= MAX_SIDES; n++) begin
      rom[n] = coeff_entry((n < MIN_SIDES) ? MIN_SIDES : n);
    end
    return rom;
  endfunction

  // cos(2pi/n), sin(2pi/n), tan(pi/n) per side count
  localparam coeff_rom_t COEFF_ROM = build_rom();

endpackage

[src/rpvg_front.sv]
module rpvg_front
  import rpvg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [RADIUS_W-1:0]   radius_i,
  input  logic [SIDES_IN_W-1:0] sides_i,
  input  coord_t                center_x_i,
  input  coord_t                center_y_i,
  input  q_status_t             q_status_i,
  output logic                  busy_o,
  output logic                  push_o,
  output job_t                  job_o
);

  localparam int PRODF_W = RADIUS_W + 1 + COEFF_W;
  localparam int TAN_HALF = 2 ** (TAN_SHIFT - 1);

  front_state_e state_q, state_d;

  logic [RADIUS_W-1:0]      radius_q;
  sides_t                   sides_q;
  coord_t                   cx_q, cy_q;
  coeff_t                   coeff_q;
  logic signed [PRODF_W-1:0] prod_q, prod_d;
  sides_t                   sides_clamp;
  logic                     accept;
  logic signed [SUM_W-1:0]  start_x_w, start_y_w;

  assign accept = start_i && (state_q == F_IDLE);

  // clamp side count into the table range
  always_comb begin
    if (sides_i < SIDES_IN_W'(MIN_SIDES)) begin
      sides_clamp = SIDES_W'(MIN_SIDES);
    end else if (int'(sides_i) > MAX_SIDES) begin
      sides_clamp = SIDES_W'(MAX_SIDES);
    end else begin
      sides_clamp = SIDES_W'(sides_i);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: if (start_i) state_d = F_MULT;
      F_MULT: state_d = F_PUSH;
      F_PUSH: if (!q_status_i.full) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    busy_o = (state_q != F_IDLE);
    push_o = (state_q == F_PUSH) && !q_status_i.full;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign prod_d = PRODF_W'(signed'({1'b0, radius_q})) * PRODF_W'(coeff_q.tan_v);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      radius_q <= radius_i;
      sides_q  <= sides_clamp;
      cx_q     <= center_x_i;
      cy_q     <= center_y_i;
      coeff_q  <= coeff_t'(COEFF_ROM[sides_clamp]);
    end
    if (state_q == F_MULT) begin
      prod_q <= prod_d;
    end
  end

  // start point: (radius*tan, radius) in Q4.20
  assign start_x_w = (SUM_W'(prod_q) + SUM_W'(TAN_HALF)) >>> TAN_SHIFT;
  assign start_y_w = SUM_W'({1'b0, radius_q}) <<< OUT_SHIFT;

  always_comb begin
    job_o.run_x    = sat_run(start_x_w);
    job_o.run_y    = sat_run(start_y_w);
    job_o.center_x = cx_q;
    job_o.center_y = cy_q;
    job_o.step_cos = coeff_q.cos_v;
    job_o.step_sin = coeff_q.sin_v;
    job_o.sides    = sides_q;
  end

endmodule

[src/rpvg_queue.sv]
module rpvg_queue
  import rpvg_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  job_t      job_i,
  input  logic      pop_i,
  output job_t      job_o,
  output q_status_t status_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) return '0;
    return p + PTR_W'(1);
  endfunction

  assign status_o.full  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign job_o          = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      priority if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end else begin
        count_q <= count_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= job_i;
  end

endmodule

[src/rpvg_back.sv]
module rpvg_back
  import rpvg_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  q_status_t        q_status_i,
  input  job_t             job_i,
  output logic             pop_o,
  output logic             valid_o,
  output coord_t           vertex_x_o,
  output coord_t           vertex_y_o,
  output logic [IDX_W-1:0] vertex_index_o,
  output logic             last_o
);

  localparam int COEFF_HALF = 2 ** (COEFF_FRAC_BITS - 1);
  localparam int OUT_HALF   = 2 ** (OUT_SHIFT - 1);
  localparam int OUTR_W     = RUN_W + 1;
  localparam int OSUM_W     = RUN_W + 2;
  localparam int COORD_MAX  = 2 ** (COORD_W - 1) - 1;
  localparam int COORD_MIN  = -(2 ** (COORD_W - 1));

  back_state_e state_q, state_d;

  run_t             run_x_q, run_y_q;
  coord_t           cx_q, cy_q;
  coeff_w_t         cos_q, sin_q;
  sides_t           left_q;
  logic [IDX_W-1:0] idx_q;
  logic             pend_q;
  logic [IDX_W-1:0] pend_idx_q;
  logic             pend_last_q;

  logic signed [PROD_W-1:0] p_xc, p_ys, p_yc, p_xs;
  logic signed [SUM_W-1:0]  sum_x, sum_y;
  run_t                     next_x, next_y;
  logic signed [OUTR_W-1:0] rnd_x, rnd_y;
  logic signed [OSUM_W-1:0] out_x, out_y;
  logic                     step;

  function automatic coord_t sat_coord(input logic signed [OSUM_W-1:0] v);
    if (v > OSUM_W'(COORD_MAX)) return coord_t'(COORD_MAX);
    if (v < OSUM_W'(COORD_MIN)) return coord_t'(COORD_MIN);
    return COORD_W'(v);
  endfunction

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: if (!q_status_i.empty) state_d = B_RUN;
      B_RUN:  if (left_q == SIDES_W'(1)) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    pop_o = (state_q == B_IDLE) && !q_status_i.empty;
    step  = (state_q == B_RUN);
  end

  // clockwise rotation by the step angle
  assign p_xc = PROD_W'(run_x_q) * PROD_W'(cos_q);
  assign p_ys = PROD_W'(run_y_q) * PROD_W'(sin_q);
  assign p_yc = PROD_W'(run_y_q) * PROD_W'(cos_q);
  assign p_xs = PROD_W'(run_x_q) * PROD_W'(sin_q);
  assign sum_x = SUM_W'(p_xc) + SUM_W'(p_ys) + SUM_W'(COEFF_HALF);
  assign sum_y = SUM_W'(p_yc) - SUM_W'(p_xs) + SUM_W'(COEFF_HALF);
  assign next_x = sat_run(sum_x >>> COEFF_FRAC_BITS);
  assign next_y = sat_run(sum_y >>> COEFF_FRAC_BITS);

  // Q4.20 -> Q3.13 plus center
  assign rnd_x = (OUTR_W'(run_x_q) + OUTR_W'(OUT_HALF)) >>> OUT_SHIFT;
  assign rnd_y = (OUTR_W'(run_y_q) + OUTR_W'(OUT_HALF)) >>> OUT_SHIFT;
  assign out_x = OSUM_W'(rnd_x) + OSUM_W'(cx_q);
  assign out_y = OSUM_W'(rnd_y) + OSUM_W'(cy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      left_q      <= '0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
      valid_o     <= 1'b0;
      last_o      <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= step;
      pend_last_q <= step && (left_q == SIDES_W'(1));
      valid_o     <= pend_q;
      last_o      <= pend_q && pend_last_q;
      if (pop_o) begin
        left_q <= job_i.sides;
      end else if (step) begin
        left_q <= left_q - SIDES_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      run_x_q <= job_i.run_x;
      run_y_q <= job_i.run_y;
      cx_q    <= job_i.center_x;
      cy_q    <= job_i.center_y;
      cos_q   <= job_i.step_cos;
      sin_q   <= job_i.step_sin;
      idx_q   <= '0;
    end else if (step) begin
      run_x_q <= next_x;
      run_y_q <= next_y;
      idx_q   <= idx_q + IDX_W'(1);
    end
    if (step) pend_idx_q <= idx_q;
    if (pend_q) begin
      vertex_x_o     <= sat_coord(out_x);
      vertex_y_o     <= sat_coord(out_y);
      vertex_index_o <= pend_idx_q;
    end
  end

endmodule

[src/regular_polygon_vertex_generator.sv]
// Regular polygon vertex generator.
// Input channel: start_i with radius_i (unsigned Q2.13 inner radius), sides_i
// and center_x_i/center_y_i (signed Q3.13). An item is taken at a rising edge
// with start_i high and busy_o low. Side counts below 3 act as 3, above 64
// as 64.
// Result channel: valid_o strobes for one cycle per vertex with vertex_x_o,
// vertex_y_o (signed Q3.13, saturated), vertex_index_o from 0 and last_o on
// the final vertex. Each polygon gives n vertices on consecutive cycles.
// Front: table lookup of cos, sin and tan, one multiply for the start point;
// busy_o stays high from the accepting edge through the multiply and push
// states (longer while the queue is full), so it takes no new item until
// the last one is pushed; it hands each polygon to a 2-entry queue.
// Back: one rotation per cycle (four parallel multipliers on the running
// point) after a load step for each polygon; it takes the next polygon
// from the queue only once all vertices of the last one are stepped.
// With the back free, an accepted item passes the front's multiply and push
// states, the queue, the back's load and first rotation step and the output
// rounding register before valid_o rises.
// The receiver cannot stall: results are never held back.
// Reset (rst_ni low, asynchronous) empties the queue and drops any polygon
// in progress; no strobe follows until a new item is taken.
module regular_polygon_vertex_generator
  import rpvg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [RADIUS_W-1:0]   radius_i,
  input  logic [SIDES_IN_W-1:0] sides_i,
  input  coord_t                center_x_i,
  input  coord_t                center_y_i,
  output logic                  valid_o,
  output coord_t                vertex_x_o,
  output coord_t                vertex_y_o,
  output logic [IDX_W-1:0]      vertex_index_o,
  output logic                  last_o
);

  // front -> queue
  logic      push;
  job_t      push_job;
  // queue -> back
  logic      pop;
  job_t      head_job;
  q_status_t q_status;

  rpvg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .radius_i   (radius_i),
    .sides_i    (sides_i),
    .center_x_i (center_x_i),
    .center_y_i (center_y_i),
    .q_status_i (q_status),
    .busy_o     (busy_o),
    .push_o     (push),
    .job_o      (push_job)
  );

  rpvg_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (push_job),
    .pop_i    (pop),
    .job_o    (head_job),
    .status_o (q_status)
  );

  rpvg_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_status_i     (q_status),
    .job_i          (head_job),
    .pop_o          (pop),
    .valid_o        (valid_o),
    .vertex_x_o     (vertex_x_o),
    .vertex_y_o     (vertex_y_o),
    .vertex_index_o (vertex_index_o),
    .last_o         (last_o)
  );

  // an accepted item makes the front busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("front not busy after accepting an item");

  // last is only marked on a strobe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> valid_o)
    else $error("last without strobe");

  // a load cycle separates polygons
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_o |=> !valid_o)
    else $error("strobe right after last vertex");

  // vertices inside a polygon come on consecutive cycles with rising index
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |=> valid_o &&
      (vertex_index_o == $past(vertex_index_o) + IDX_W'(1)))
    else $error("vertex sequence broken");

endmodule
